### hw/rtl/occupancy_grid_ray_update_unit_macros.svh
// Assertion macros used by the occupancy grid ray update checker.
`ifndef OCCUPANCY_GRID_RAY_UPDATE_UNIT_MACROS_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define OGRU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define OGRU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hw/rtl/ogru_pkg.sv
// Types, constants and helper functions of the occupancy grid ray update unit.
package ogru_pkg;

    localparam int GRID_ROWS  = 256;
    localparam int GRID_COLS  = 256;
    localparam int STORE_SIZE = GRID_ROWS * GRID_COLS;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int ROW_W      = $clog2(GRID_ROWS);
    localparam int COL_W      = $clog2(GRID_COLS);

    localparam int CELL_W   = 16;
    localparam int IN_CRD_W = 11;
    localparam int COORD_W  = 12;   // one bit of headroom over the input coordinates
    localparam int DIM_W    = 13;   // holds map sizes and the largest grid dimension
    localparam int MAP_W    = 9;
    localparam int OFS_W    = 11;   // distance from the start along one axis
    localparam int ERR_W    = 14;
    localparam int D2_W     = 24;
    localparam int LIM_W    = 18;
    localparam int CNT_W    = 10;

    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_FREE_DELTA  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_OCC_DELTA   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PRIOR_LEVEL = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STOP_LEVEL  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAP_ROWS    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MAP_COLS    = 3'd5;

    localparam logic [CELL_W-1:0] FREE_DELTA_RST  = 16'hFF27;
    localparam logic [CELL_W-1:0] OCC_DELTA_RST   = 16'd217;
    localparam logic [CELL_W-1:0] PRIOR_LEVEL_RST = 16'd0;
    localparam logic [CELL_W-1:0] STOP_LEVEL_RST  = 16'd25600;
    localparam logic [MAP_W-1:0]  MAP_ROWS_RST    = 9'd256;
    localparam logic [MAP_W-1:0]  MAP_COLS_RST    = 9'd256;

    // Operation codes.
    localparam logic [1:0] OP_RAY  = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_FILL = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_RAY_CHECK,
        ST_RAY_UPDATE,
        ST_HIT,
        ST_READ_ADDR,
        ST_READ_DATA,
        ST_DONE
    } state_t;

    function automatic logic [CELL_W-1:0] sat_add(input logic [CELL_W-1:0] a,
                                                   input logic [CELL_W-1:0] b);
        logic [CELL_W:0] sum;
        sum = {a[CELL_W-1], a} + {b[CELL_W-1], b};
        if (sum[CELL_W] != sum[CELL_W-1]) begin
            return sum[CELL_W] ? {1'b1, {(CELL_W-1){1'b0}}} : {1'b0, {(CELL_W-1){1'b1}}};
        end
        return sum[CELL_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                     input logic [COORD_W-1:0] c);
        return ADDR_W'(ADDR_W'(r[ROW_W-1:0]) * ADDR_W'(GRID_COLS)) + ADDR_W'(c[COL_W-1:0]);
    endfunction

    function automatic logic in_map(input logic [COORD_W-1:0] r,
                                    input logic [COORD_W-1:0] c,
                                    input logic [MAP_W-1:0]   rows,
                                    input logic [MAP_W-1:0]   cols);
        logic [DIM_W-1:0] rows_use;
        logic [DIM_W-1:0] cols_use;
        rows_use = (DIM_W'(rows) > DIM_W'(GRID_ROWS)) ? DIM_W'(GRID_ROWS) : DIM_W'(rows);
        cols_use = (DIM_W'(cols) > DIM_W'(GRID_COLS)) ? DIM_W'(GRID_COLS) : DIM_W'(cols);
        return !r[COORD_W-1] && !c[COORD_W-1]
            && (DIM_W'(r[COORD_W-2:0]) < rows_use)
            && (DIM_W'(c[COORD_W-2:0]) < cols_use);
    endfunction

endpackage

### hw/rtl/ogru_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ogru_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/occupancy_grid_ray_update_unit.sv
// Ray update: each ray cell is read, then written back, on the single cell RAM; a ray ends
// in ST_HIT and ST_DONE, and a stop cell that ends it is read again first. A cell read
// passes ST_READ_ADDR and ST_READ_DATA, a fill writes every cell, unused ops go to ST_DONE.
// After aresetn (synchronous, active low) a clearing pass writes zero to all 65536
// cells; the block accepts no transaction while it runs, register writes still work.
// Results leave through an output register, so the next ray is walked while a result waits.
module occupancy_grid_ray_update_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // {hit_valid, op}
    input  logic [ogru_pkg::S_TUSER_W-1:0]    s_tuser,
    // {pad, range_limit_sq, end_col, end_row, start_col, start_row}
    input  logic [ogru_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // {pad, free_count, cell_value}
    output logic [ogru_pkg::M_TDATA_W-1:0]    m_tdata,
    // {outside, hit_applied}
    output logic [ogru_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ogru_pkg::PADDR_W-1:0]      paddr,
    input  logic [ogru_pkg::PDATA_W-1:0]      pwdata,
    output logic [ogru_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam logic [ogru_pkg::ADDR_W-1:0] LAST_ADDR = ogru_pkg::ADDR_W'(ogru_pkg::STORE_SIZE - 1);

    // Configuration registers.
    logic [ogru_pkg::CELL_W-1:0] free_delta_reg, occ_delta_reg, prior_level_reg, stop_level_reg;
    logic [ogru_pkg::MAP_W-1:0]  map_rows_reg, map_cols_reg;
    logic [ogru_pkg::REG_IDX_W-1:0] reg_idx;
    logic cfg_wr;

    // Control state.
    ogru_pkg::state_t state_reg, state_next;
    logic [ogru_pkg::ADDR_W-1:0] sweep_reg, sweep_next;
    logic fill_zero_reg, fill_zero_next;
    logic m_valid_reg, m_valid_next;

    // Walk state.
    logic [ogru_pkg::COORD_W-1:0] r_reg, r_next, c_reg, c_next;
    logic [ogru_pkg::COORD_W-1:0] r1_reg, r1_next, c1_reg, c1_next;
    logic [ogru_pkg::LIM_W-1:0]   lim_reg, lim_next;
    logic hit_reg, hit_next;
    logic signed [ogru_pkg::ERR_W-1:0] dr_reg, dr_next, dc_reg, dc_next, err_reg, err_next;
    logic sr_neg_reg, sr_neg_next, sc_neg_reg, sc_neg_next;
    logic [ogru_pkg::OFS_W-1:0] ar_reg, ar_next, ac_reg, ac_next;
    logic [ogru_pkg::D2_W-1:0]  d2_reg, d2_next;
    logic [ogru_pkg::CNT_W-1:0] count_reg, count_next;
    logic [ogru_pkg::CELL_W-1:0] value_reg, value_next;
    logic applied_reg, applied_next, outs_reg, outs_next;

    // Result register.
    logic [ogru_pkg::CELL_W-1:0] m_value_reg, m_value_next;
    logic [ogru_pkg::CNT_W-1:0]  m_count_reg, m_count_next;
    logic m_applied_reg, m_applied_next, m_outs_reg, m_outs_next;

    // Cell RAM interface.
    logic ram_we;
    logic [ogru_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [ogru_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

    // Input fields.
    logic [1:0] in_op;
    logic in_hit;
    logic signed [ogru_pkg::COORD_W-1:0] in_r0, in_c0, in_r1, in_c1;
    logic [ogru_pkg::LIM_W-1:0] in_lim;
    logic signed [ogru_pkg::ERR_W-1:0] in_dr, in_dc;

    // Walk helpers.
    logic cur_in_map, at_end, out_free;
    logic signed [ogru_pkg::ERR_W:0] e2;
    logic step_r, step_c;
    logic [ogru_pkg::D2_W-1:0] d2_add_r, d2_add_c;

    assign in_op  = s_tuser[1:0];
    assign in_hit = s_tuser[2];
    assign in_r0  = {s_tdata[10], s_tdata[10:0]};
    assign in_c0  = {s_tdata[21], s_tdata[21:11]};
    assign in_r1  = {s_tdata[32], s_tdata[32:22]};
    assign in_c1  = {s_tdata[43], s_tdata[43:33]};
    assign in_lim = s_tdata[61:44];

    assign in_dr = (in_r1 > in_r0) ? ogru_pkg::ERR_W'(in_r1 - in_r0)
                                   : ogru_pkg::ERR_W'(in_r0 - in_r1);
    // The column term is kept negative, as minus the column distance.
    assign in_dc = (in_c1 > in_c0) ? ogru_pkg::ERR_W'(in_c0 - in_c1)
                                   : ogru_pkg::ERR_W'(in_c1 - in_c0);

    assign cur_in_map = ogru_pkg::in_map(r_reg, c_reg, map_rows_reg, map_cols_reg);
    assign at_end     = (r_reg == r1_reg) && (c_reg == c1_reg);
    assign out_free   = !m_valid_reg || m_tready;

    assign e2       = {err_reg, 1'b0};
    assign step_r   = e2 >= $signed({dc_reg[ogru_pkg::ERR_W-1], dc_reg});
    assign step_c   = e2 <= $signed({dr_reg[ogru_pkg::ERR_W-1], dr_reg});
    // (a + 1)^2 - a^2 = 2a + 1
    assign d2_add_r = step_r ? ogru_pkg::D2_W'({ar_reg, 1'b1}) : '0;
    assign d2_add_c = step_c ? ogru_pkg::D2_W'({ac_reg, 1'b1}) : '0;

    assign ram_raddr = ogru_pkg::cell_addr(r_reg, c_reg);

    ogru_ram #(
        .WIDTH (ogru_pkg::CELL_W),
        .DEPTH (ogru_pkg::STORE_SIZE)
    ) u_cell_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        fill_zero_next = fill_zero_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        r_next   = r_reg;
        c_next   = c_reg;
        r1_next  = r1_reg;
        c1_next  = c1_reg;
        lim_next = lim_reg;
        hit_next = hit_reg;
        dr_next  = dr_reg;
        dc_next  = dc_reg;
        err_next = err_reg;
        sr_neg_next = sr_neg_reg;
        sc_neg_next = sc_neg_reg;
        ar_next  = ar_reg;
        ac_next  = ac_reg;
        d2_next  = d2_reg;
        count_next   = count_reg;
        value_next   = value_reg;
        applied_next = applied_reg;
        outs_next    = outs_reg;
        m_value_next   = m_value_reg;
        m_count_next   = m_count_reg;
        m_applied_next = m_applied_reg;
        m_outs_next    = m_outs_reg;
        ram_we    = 1'b0;
        ram_waddr = ram_raddr;
        ram_wdata = ogru_pkg::sat_add(ram_rdata, free_delta_reg);
        s_tready  = 1'b0;

        unique case (state_reg)
            ogru_pkg::ST_FILL: begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                ram_wdata  = fill_zero_reg ? '0 : prior_level_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_ADDR) begin
                    state_next = fill_zero_reg ? ogru_pkg::ST_IDLE : ogru_pkg::ST_DONE;
                end
            end
            ogru_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    r_next   = in_r0;
                    c_next   = in_c0;
                    r1_next  = in_r1;
                    c1_next  = in_c1;
                    lim_next = in_lim;
                    hit_next = in_hit;
                    dr_next  = in_dr;
                    dc_next  = in_dc;
                    err_next = in_dr + in_dc;
                    sr_neg_next = !(in_r0 < in_r1);
                    sc_neg_next = !(in_c0 < in_c1);
                    ar_next  = '0;
                    ac_next  = '0;
                    d2_next  = '0;
                    count_next   = '0;
                    value_next   = '0;
                    applied_next = 1'b0;
                    outs_next    = 1'b0;
                    unique case (in_op)
                        ogru_pkg::OP_RAY:  state_next = ogru_pkg::ST_RAY_CHECK;
                        ogru_pkg::OP_READ: state_next = ogru_pkg::ST_READ_ADDR;
                        ogru_pkg::OP_FILL: begin
                            state_next     = ogru_pkg::ST_FILL;
                            fill_zero_next = 1'b0;
                            sweep_next     = '0;
                        end
                        ogru_pkg::OP_NOP:  state_next = ogru_pkg::ST_DONE;
                        default:           state_next = ogru_pkg::ST_DONE;
                    endcase
                end
            end
            ogru_pkg::ST_RAY_CHECK: begin
                // The RAM reads the current cell at this edge either way.
                if (at_end || (d2_reg >= ogru_pkg::D2_W'(lim_reg)) || !cur_in_map) begin
                    state_next = ogru_pkg::ST_HIT;
                end else begin
                    state_next = ogru_pkg::ST_RAY_UPDATE;
                end
            end
            ogru_pkg::ST_RAY_UPDATE: begin
                if (ram_rdata == stop_level_reg) begin
                    // The cell is read again at this edge, so its value is ready in ST_HIT.
                    state_next = ogru_pkg::ST_HIT;
                end else begin
                    ram_we     = 1'b1;
                    count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
                    err_next   = err_reg + (step_r ? dc_reg : '0) + (step_c ? dr_reg : '0);
                    d2_next    = d2_reg + d2_add_r + d2_add_c;
                    if (step_r) begin
                        r_next  = sr_neg_reg ? r_reg - 1'b1 : r_reg + 1'b1;
                        ar_next = ar_reg + 1'b1;
                    end
                    if (step_c) begin
                        c_next  = sc_neg_reg ? c_reg - 1'b1 : c_reg + 1'b1;
                        ac_next = ac_reg + 1'b1;
                    end
                    state_next = ogru_pkg::ST_RAY_CHECK;
                end
            end
            ogru_pkg::ST_HIT: begin
                ram_wdata = ogru_pkg::sat_add(ram_rdata, occ_delta_reg);
                if (!cur_in_map) begin
                    outs_next = 1'b1;
                end else if (hit_reg) begin
                    ram_we       = 1'b1;
                    value_next   = ram_wdata;
                    applied_next = 1'b1;
                end
                state_next = ogru_pkg::ST_DONE;
            end
            ogru_pkg::ST_READ_ADDR: begin
                if (cur_in_map) begin
                    state_next = ogru_pkg::ST_READ_DATA;
                end else begin
                    outs_next  = 1'b1;
                    state_next = ogru_pkg::ST_DONE;
                end
            end
            ogru_pkg::ST_READ_DATA: begin
                value_next = ram_rdata;
                state_next = ogru_pkg::ST_DONE;
            end
            ogru_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_value_next   = value_reg;
                    m_count_next   = count_reg;
                    m_applied_next = applied_reg;
                    m_outs_next    = outs_reg;
                    state_next     = ogru_pkg::ST_IDLE;
                end
            end
            default: state_next = ogru_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ogru_pkg::ST_FILL;
            sweep_reg     <= '0;
            fill_zero_reg <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            fill_zero_reg <= fill_zero_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        r_reg   <= r_next;
        c_reg   <= c_next;
        r1_reg  <= r1_next;
        c1_reg  <= c1_next;
        lim_reg <= lim_next;
        hit_reg <= hit_next;
        dr_reg  <= dr_next;
        dc_reg  <= dc_next;
        err_reg <= err_next;
        sr_neg_reg <= sr_neg_next;
        sc_neg_reg <= sc_neg_next;
        ar_reg  <= ar_next;
        ac_reg  <= ac_next;
        d2_reg  <= d2_next;
        count_reg   <= count_next;
        value_reg   <= value_next;
        applied_reg <= applied_next;
        outs_reg    <= outs_next;
        m_value_reg   <= m_value_next;
        m_count_reg   <= m_count_next;
        m_applied_reg <= m_applied_next;
        m_outs_reg    <= m_outs_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(ogru_pkg::M_TDATA_W - ogru_pkg::CELL_W - ogru_pkg::CNT_W){1'b0}},
                       m_count_reg, m_value_reg};
    assign m_tuser  = {m_outs_reg, m_applied_reg};

    // Configuration port.
    assign pready  = 1'b1;
    assign reg_idx = paddr[ogru_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_delta_reg  <= ogru_pkg::FREE_DELTA_RST;
            occ_delta_reg   <= ogru_pkg::OCC_DELTA_RST;
            prior_level_reg <= ogru_pkg::PRIOR_LEVEL_RST;
            stop_level_reg  <= ogru_pkg::STOP_LEVEL_RST;
            map_rows_reg    <= ogru_pkg::MAP_ROWS_RST;
            map_cols_reg    <= ogru_pkg::MAP_COLS_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                ogru_pkg::REG_FREE_DELTA:  free_delta_reg  <= pwdata[ogru_pkg::CELL_W-1:0];
                ogru_pkg::REG_OCC_DELTA:   occ_delta_reg   <= pwdata[ogru_pkg::CELL_W-1:0];
                ogru_pkg::REG_PRIOR_LEVEL: prior_level_reg <= pwdata[ogru_pkg::CELL_W-1:0];
                ogru_pkg::REG_STOP_LEVEL:  stop_level_reg  <= pwdata[ogru_pkg::CELL_W-1:0];
                ogru_pkg::REG_MAP_ROWS:    map_rows_reg    <= pwdata[ogru_pkg::MAP_W-1:0];
                ogru_pkg::REG_MAP_COLS:    map_cols_reg    <= pwdata[ogru_pkg::MAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ogru_pkg::REG_FREE_DELTA:  prdata = ogru_pkg::PDATA_W'(free_delta_reg);
            ogru_pkg::REG_OCC_DELTA:   prdata = ogru_pkg::PDATA_W'(occ_delta_reg);
            ogru_pkg::REG_PRIOR_LEVEL: prdata = ogru_pkg::PDATA_W'(prior_level_reg);
            ogru_pkg::REG_STOP_LEVEL:  prdata = ogru_pkg::PDATA_W'(stop_level_reg);
            ogru_pkg::REG_MAP_ROWS:    prdata = ogru_pkg::PDATA_W'(map_rows_reg);
            ogru_pkg::REG_MAP_COLS:    prdata = ogru_pkg::PDATA_W'(map_cols_reg);
            default:                   prdata = '0;
        endcase
    end

endmodule

### hw/rtl/ogru_checker.sv
// Port-level assertions for the occupancy grid ray update unit, bound to the top level.
`include "occupancy_grid_ray_update_unit_macros.svh"

module ogru_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ogru_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [ogru_pkg::M_TUSER_W-1:0] m_tuser
);

    // Reset starts the clearing pass, so nothing is accepted or offered right after it.
    `OGRU_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !s_tready && !m_tvalid, "block not quiet after reset")

    // An accepted transaction keeps the block busy for at least the next cycle.
    `OGRU_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "ready stayed high after accept")

    // A result that lies outside the map never carries an applied hit or a cell value.
    `OGRU_ASSERT(a_outside_clean, m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata[15:0] == 16'd0, "outside result carries hit data")

    `OGRU_ASSERT(a_result_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind occupancy_grid_ray_update_unit ogru_checker u_ogru_checker (.*);

### tb/occupancy_grid_ray_update_unit_test.sv
// Self-checking testbench for the occupancy grid ray update unit: directed table, then random phases.
module occupancy_grid_ray_update_unit_test;
    import ogru_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 5_000_000;
    localparam int          HOLD_CYCLES = 400;

    typedef struct {
        logic [1:0]         op;
        logic signed [10:0] start_row;
        logic signed [10:0] start_col;
        logic signed [10:0] end_row;
        logic signed [10:0] end_col;
        logic [17:0]        range_limit_sq;
        logic               hit_valid;
    } grid_cmd_t;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [9:0]  free_count;
        logic        hit_applied;
        logic        outside;
    } grid_resp_t;

    typedef struct {
        grid_cmd_t  cmd;
        bit         typed;
        grid_resp_t resp;
    } directed_row_t;

    typedef struct {
        logic [15:0] free_delta;
        logic [15:0] occ_delta;
        logic [15:0] prior_level;
        logic [15:0] stop_level;
        logic [8:0]  map_rows;
        logic [8:0]  map_cols;
        bit          fill_first;
        bit          shuffle;
        int          items;
    } phase_cfg_t;

    logic                 aclk;
    logic                 aresetn;
    logic [S_TUSER_W-1:0] s_tuser;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    occupancy_grid_ray_update_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the grid and the registers.
    logic [15:0] grid_model [0:STORE_SIZE-1];
    logic [15:0] cfg_free_delta  = 16'hFF27;
    logic [15:0] cfg_occ_delta   = 16'd217;
    logic [15:0] cfg_prior_level = 16'd0;
    logic [15:0] cfg_stop_level  = 16'd25600;
    logic [8:0]  cfg_map_rows    = 9'd256;
    logic [8:0]  cfg_map_cols    = 9'd256;

    grid_resp_t  awaited_results [$];
    int unsigned error_count;
    int unsigned cycle_count;
    bit          burst_mode;
    bit          hold_req;
    int          hold_left;
    int          stall_left;

    directed_row_t dir_table [24] = '{
        '{'{OP_READ, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0}},
        '{'{OP_READ, -1024, -1024, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 1}},
        '{'{OP_READ, 1023, 1023, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 1}},
        '{'{OP_READ, 255, 255, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0}},
        '{'{OP_NOP, -1, -1, -1, -1, 262143, 1}, 1'b1, '{0, 0, 0, 0}},
        '{'{OP_RAY, 10, 10, 10, 10, 262143, 1}, 1'b1, '{217, 0, 1, 0}},
        '{'{OP_RAY, 10, 10, 10, 20, 262143, 1}, 1'b1, '{217, 10, 1, 0}},
        '{'{OP_RAY, 10, 10, 10, 20, 262143, 0}, 1'b0, '{0, 0, 0, 0}},
        '{'{OP_RAY, 20, 20, 30, 30, 0, 1}, 1'b1, '{217, 0, 1, 0}},
        '{'{OP_RAY, 20, 20, 30, 30, 1, 1}, 1'b0, '{0, 0, 0, 0}},
        '{'{OP_RAY, -5, -5, 10, 10, 262143, 1}, 1'b1, '{0, 0, 0, 1}},
        '{'{OP_RAY, 250, 250, 300, 300, 262143, 1}, 1'b1, '{0, 6, 0, 1}},
        '{'{OP_RAY, -1024, -1024, 1023, 1023, 262143, 1}, 1'b1, '{0, 0, 0, 1}},
        '{'{OP_RAY, 0, 0, 1023, 1023, 262143, 1}, 1'b0, '{0, 0, 0, 0}},
        '{'{OP_RAY, 0, 255, 255, 0, 262143, 1}, 1'b0, '{0, 0, 0, 0}},
        '{'{OP_RAY, 0, 0, 255, 3, 262143, 1}, 1'b0, '{0, 0, 0, 0}},
        '{'{OP_RAY, 200, 100, -50, -1000, 262143, 0}, 1'b0, '{0, 0, 0, 0}},
        '{'{OP_RAY, 128, 128, 1023, -1024, 5000, 1}, 1'b0, '{0, 0, 0, 0}},
        '{'{OP_READ, 10, 15, 0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0}},
        '{'{OP_FILL, 0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0}},
        '{'{OP_READ, 10, 15, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0}},
        '{'{OP_RAY, 5, 7, 5, 7, 0, 0}, 1'b1, '{0, 0, 0, 0}},
        '{'{OP_READ, -1, 255, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 1}},
        '{'{OP_READ, 0, 256, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 1}}
    };

    // Stop levels are chosen so that repeated passes drive cells onto them.
    phase_cfg_t phase_table [7] = '{
        '{-256, 256, 0, -768, 256, 256, 1'b1, 1'b0, 180},
        '{32767, -32768, -32768, 32767, 40, 17, 1'b1, 1'b0, 180},
        '{-32768, 32767, 32767, -32768, 511, 300, 1'b1, 1'b0, 180},
        '{100, -100, 0, 0, 0, 256, 1'b0, 1'b0, 80},
        '{3, -3, -9, 0, 1, 256, 1'b1, 1'b0, 180},
        '{1, -1, -5, 0, 200, 0, 1'b0, 1'b0, 60},
        '{0, 0, 0, 0, 0, 0, 1'b0, 1'b1, 180}
    };

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[occupancy_grid_ray_update_unit] ERROR");
            $finish;
        end
    end

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("%s", msg);
    endtask

    function automatic logic [15:0] add_log_odds(input logic [15:0] a, input logic [15:0] b);
        int s;
        s = int'($signed(a)) + int'($signed(b));
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        return 16'(s);
    endfunction

    function automatic bit cell_inside(input int r, input int c);
        int rows_use;
        int cols_use;
        rows_use = (int'(cfg_map_rows) > GRID_ROWS) ? GRID_ROWS : int'(cfg_map_rows);
        cols_use = (int'(cfg_map_cols) > GRID_COLS) ? GRID_COLS : int'(cfg_map_cols);
        return r >= 0 && c >= 0 && r < rows_use && c < cols_use;
    endfunction

    // Updates the shadow grid for one command and returns the response it should give.
    function automatic grid_resp_t apply_grid_update(input grid_cmd_t cmd);
        grid_resp_t  resp;
        int          r0, c0, r1, c1, dr, dc, sr, sc, err, e2, r, c;
        longint      d2, lim;
        int unsigned idx;
        resp = '0;
        r0 = cmd.start_row;
        c0 = cmd.start_col;
        r1 = cmd.end_row;
        c1 = cmd.end_col;
        lim = longint'(cmd.range_limit_sq);
        case (cmd.op)
            OP_RAY: begin
                dr = (r1 > r0) ? r1 - r0 : r0 - r1;
                dc = (c1 > c0) ? c0 - c1 : c1 - c0;
                sr = (r0 < r1) ? 1 : -1;
                sc = (c0 < c1) ? 1 : -1;
                err = dr + dc;
                r = r0;
                c = c0;
                forever begin
                    d2 = longint'(r - r0) * (r - r0) + longint'(c - c0) * (c - c0);
                    if ((r == r1 && c == c1) || d2 >= lim || !cell_inside(r, c)) break;
                    idx = r * GRID_COLS + c;
                    if (grid_model[idx] == cfg_stop_level) break;
                    grid_model[idx] = add_log_odds(grid_model[idx], cfg_free_delta);
                    if (resp.free_count < 10'd1023) resp.free_count++;
                    e2 = 2 * err;
                    if (e2 >= dc) begin
                        err += dc;
                        r += sr;
                    end
                    if (e2 <= dr) begin
                        err += dr;
                        c += sc;
                    end
                end
                if (!cell_inside(r, c)) begin
                    resp.outside = 1'b1;
                end else if (cmd.hit_valid) begin
                    idx = r * GRID_COLS + c;
                    grid_model[idx] = add_log_odds(grid_model[idx], cfg_occ_delta);
                    resp.cell_value = grid_model[idx];
                    resp.hit_applied = 1'b1;
                end
            end
            OP_READ: begin
                if (cell_inside(r0, c0)) resp.cell_value = grid_model[r0 * GRID_COLS + c0];
                else resp.outside = 1'b1;
            end
            OP_FILL: begin
                foreach (grid_model[k]) grid_model[k] = cfg_prior_level;
            end
            default: ;
        endcase
        return resp;
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (burst_mode || sel < 55) return 0;
        if (sel < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    // Most coordinates land in a small corner patch so rays keep revisiting cells.
    function automatic logic signed [10:0] pick_coord(input int span);
        int sel;
        sel = $urandom_range(0, 99);
        if (span > 0 && sel < 50) return 11'($urandom_range(0, ((span < 16) ? span : 16) - 1));
        if (span > 0 && sel < 80) return 11'($urandom_range(0, span - 1));
        return 11'($urandom);
    endfunction

    function automatic logic signed [10:0] pick_end(input logic signed [10:0] from);
        int sel;
        int e;
        sel = $urandom_range(0, 99);
        if (sel < 70) e = int'(from) + int'($urandom_range(0, 24)) - 12;
        else if (sel < 90) e = int'(from) + int'($urandom_range(0, 600)) - 300;
        else e = int'($signed(11'($urandom)));
        if (e > 1023) e = 1023;
        if (e < -1024) e = -1024;
        return 11'(e);
    endfunction

    function automatic grid_cmd_t random_cmd();
        grid_cmd_t cmd;
        int        sel;
        int        rows_use;
        int        cols_use;
        rows_use = (int'(cfg_map_rows) > GRID_ROWS) ? GRID_ROWS : int'(cfg_map_rows);
        cols_use = (int'(cfg_map_cols) > GRID_COLS) ? GRID_COLS : int'(cfg_map_cols);
        sel = $urandom_range(0, 99);
        cmd.op = (sel < 66) ? OP_RAY : (sel < 94) ? OP_READ : OP_NOP;
        cmd.start_row = pick_coord(rows_use);
        cmd.start_col = pick_coord(cols_use);
        cmd.end_row = pick_end(cmd.start_row);
        cmd.end_col = pick_end(cmd.start_col);
        sel = $urandom_range(0, 99);
        if (sel < 60) cmd.range_limit_sq = 18'h3FFFF;
        else if (sel < 80) cmd.range_limit_sq = 18'($urandom_range(0, 400));
        else if (sel < 95) cmd.range_limit_sq = 18'($urandom);
        else cmd.range_limit_sq = '0;
        cmd.hit_valid = 1'($urandom);
        return cmd;
    endfunction

    // Called at a falling edge; returns at a falling edge after the transaction.
    task automatic send_cmd(input grid_cmd_t cmd, input bit typed, input grid_resp_t typed_resp);
        int         gap;
        grid_resp_t predicted;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {cmd.hit_valid, cmd.op};
        s_tdata <= {2'b00, cmd.range_limit_sq, cmd.end_col, cmd.end_row,
                    cmd.start_col, cmd.start_row};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_grid_update(cmd);
        awaited_results.insert(awaited_results.size(), typed ? typed_resp : predicted);
        @(negedge aclk);
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Write, then read back; starts and ends at a falling edge.
    task automatic program_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        mask = (idx <= REG_STOP_LEVEL) ? 32'h0000_FFFF : 32'h0000_01FF;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= value & mask;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_FREE_DELTA:  cfg_free_delta = value[15:0];
            REG_OCC_DELTA:   cfg_occ_delta = value[15:0];
            REG_PRIOR_LEVEL: cfg_prior_level = value[15:0];
            REG_STOP_LEVEL:  cfg_stop_level = value[15:0];
            REG_MAP_ROWS:    cfg_map_rows = value[8:0];
            REG_MAP_COLS:    cfg_map_cols = value[8:0];
            default: ;
        endcase
        @(negedge aclk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if ((prdata & mask) !== (value & mask))
            note_error($sformatf("register %0d read back %h, expected %h",
                                 idx, prdata & mask, value & mask));
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Result side: random back-pressure plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
                m_tready <= (stall_left == 0);
            end
        end
    end

    initial begin
        grid_resp_t got;
        grid_resp_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.cell_value = m_tdata[15:0];
                got.free_count = m_tdata[25:16];
                got.hit_applied = m_tuser[0];
                got.outside = m_tuser[1];
                if (awaited_results.size() == 0) begin
                    note_error($sformatf("result with nothing pending: value %0d count %0d hit %0b out %0b",
                                         $signed(got.cell_value), got.free_count,
                                         got.hit_applied, got.outside));
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want)
                        note_error($sformatf({"mismatch: cell_value %0d/%0d free_count %0d/%0d ",
                                              "hit_applied %0b/%0b outside %0b/%0b (expected/actual)"},
                                             $signed(want.cell_value), $signed(got.cell_value),
                                             want.free_count, got.free_count,
                                             want.hit_applied, got.hit_applied,
                                             want.outside, got.outside));
                end
            end
        end
    end

    initial begin
        grid_cmd_t  cmd;
        phase_cfg_t ph;
        grid_resp_t no_resp;
        no_resp = '0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        foreach (grid_model[k]) grid_model[k] = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_table[i]) send_cmd(dir_table[i].cmd, dir_table[i].typed, dir_table[i].resp);

        foreach (phase_table[p]) begin
            quiesce();
            ph = phase_table[p];
            if (ph.shuffle) begin
                ph.free_delta = 16'($urandom);
                ph.occ_delta = 16'($urandom);
                ph.prior_level = 16'($urandom);
                ph.stop_level = 16'($urandom);
                ph.map_rows = 9'($urandom_range(0, 511));
                ph.map_cols = 9'($urandom_range(0, 511));
            end
            program_register(REG_FREE_DELTA, {16'h0, ph.free_delta});
            program_register(REG_OCC_DELTA, {16'h0, ph.occ_delta});
            program_register(REG_PRIOR_LEVEL, {16'h0, ph.prior_level});
            program_register(REG_STOP_LEVEL, {16'h0, ph.stop_level});
            program_register(REG_MAP_ROWS, {23'h0, ph.map_rows});
            program_register(REG_MAP_COLS, {23'h0, ph.map_cols});
            for (int k = 0; k < ph.items; k++) begin
                burst_mode = (k % 60) >= 45;
                // Hold the result side off while input keeps coming so the unit backs up.
                if (p == 0 && k == 60) hold_req = 1'b1;
                cmd = random_cmd();
                if (k == 0 && ph.fill_first) cmd.op = OP_FILL;
                send_cmd(cmd, 1'b0, no_resp);
            end
        end

        burst_mode = 1'b0;
        quiesce();
        repeat (20) @(posedge aclk);
        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("[occupancy_grid_ray_update_unit] OK");
        end else begin
            $display("[occupancy_grid_ray_update_unit] ERROR");
        end
        $finish;
    end

endmodule
